>>> hw/rtl/fhfr_pkg.sv
`timescale 1ns / 1ps

package fhfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int HDR_LEN    = 3;
    localparam int FRAME_LEN  = 18;
    localparam int STORE_LEN  = FRAME_LEN - 1;
    localparam int HDR_CNT_W  = 2;
    localparam int IDX_W      = 5;
    localparam int FRAME_W    = FRAME_LEN * BYTE_W;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [FRAME_W-1:0]   frame_t;
    typedef logic [HDR_CNT_W-1:0] hdr_cnt_t;
    typedef logic [IDX_W-1:0]     idx_t;

    localparam byte_t    HDR_BYTE     = 8'h41;
    localparam hdr_cnt_t HDR_LAST     = hdr_cnt_t'(HDR_LEN - 1);
    localparam idx_t     PAYLOAD_LAST = idx_t'(FRAME_LEN - 1);

endpackage

>>> hw/rtl/fhfr_in_reg.sv
`timescale 1ns / 1ps

module fhfr_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  fhfr_pkg::byte_t s_axis_tdata,    // rx_byte
    output logic           in_valid,
    output fhfr_pkg::byte_t in_data,
    input  logic           in_consume
);
    import fhfr_pkg::*;

    logic  in_valid_reg;
    logic  in_valid_next;
    byte_t in_data_reg;

    assign s_axis_tready = !in_valid_reg || in_consume;
    assign in_valid      = in_valid_reg;
    assign in_data       = in_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready) begin
            in_valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_data_reg <= s_axis_tdata;
        end
    end

endmodule

>>> hw/rtl/fhfr_frame.sv
`timescale 1ns / 1ps

module fhfr_frame (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  fhfr_pkg::byte_t  in_data,
    output logic             in_consume,
    output logic             res_valid,
    input  logic             res_ready,
    output fhfr_pkg::frame_t res_data
);
    import fhfr_pkg::*;

    hdr_cnt_t hdr_cnt_reg;
    hdr_cnt_t hdr_cnt_next;
    logic     in_payload_reg;
    logic     in_payload_next;
    idx_t     idx_reg;
    idx_t     idx_next;
    byte_t    store_reg [STORE_LEN];
    logic     last_byte;
    logic     take;

    // last payload byte closes the frame
    assign last_byte  = in_payload_reg && (idx_reg == PAYLOAD_LAST);
    assign res_valid  = in_valid && last_byte;
    assign in_consume = in_valid && (!last_byte || res_ready);
    assign take       = in_consume;

    always_comb begin
        for (int i = 0; i < STORE_LEN; i++) begin
            res_data[i*BYTE_W +: BYTE_W] = store_reg[i];
        end
        res_data[STORE_LEN*BYTE_W +: BYTE_W] = in_data;
    end

    always_comb begin
        hdr_cnt_next    = hdr_cnt_reg;
        in_payload_next = in_payload_reg;
        idx_next        = idx_reg;
        if (take) begin
            if (!in_payload_reg) begin
                if (in_data == HDR_BYTE) begin
                    if (hdr_cnt_reg == HDR_LAST) begin
                        hdr_cnt_next    = '0;
                        in_payload_next = 1'b1;
                        idx_next        = '0;
                    end else begin
                        hdr_cnt_next = hdr_cnt_reg + hdr_cnt_t'(1);
                    end
                end else begin
                    hdr_cnt_next = '0;
                end
            end else if (last_byte) begin
                in_payload_next = 1'b0;
                idx_next        = '0;
                hdr_cnt_next    = '0;
            end else begin
                idx_next = idx_reg + idx_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_cnt_reg    <= '0;
            in_payload_reg <= 1'b0;
            idx_reg        <= '0;
        end else begin
            hdr_cnt_reg    <= hdr_cnt_next;
            in_payload_reg <= in_payload_next;
            idx_reg        <= idx_next;
        end
    end

    // payload shifts down; after 17 bytes entry 0 holds payload byte 0
    always_ff @(posedge aclk) begin
        if (take && in_payload_reg && !last_byte) begin
            for (int i = 0; i < STORE_LEN - 1; i++) begin
                store_reg[i] <= store_reg[i+1];
            end
            store_reg[STORE_LEN-1] <= in_data;
        end
    end

endmodule

>>> hw/rtl/fhfr_out_reg.sv
`timescale 1ns / 1ps

module fhfr_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    output logic             res_ready,
    input  fhfr_pkg::frame_t res_data,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output fhfr_pkg::frame_t m_axis_tdata
);
    import fhfr_pkg::*;

    logic   out_valid_reg;
    logic   out_valid_next;
    frame_t out_data_reg;

    assign res_ready     = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_ready) begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_data_reg <= res_data;
        end
    end

endmodule

>>> hw/rtl/fixed_header_frame_receiver_core.sv
`timescale 1ns / 1ps

// Byte-stream frame receiver. Each input transaction carries one received byte.
// The core hunts for three consecutive 0x41 ('A') bytes, then takes exactly the
// next 18 bytes as payload and emits one output transaction holding them, after
// which it hunts again; an 'A' inside the payload is plain data. The core takes
// one byte per clock cycle unless stalled: a byte sits in the input register
// while the header/payload state updates, and a finished frame is loaded into
// the output register on m_axis as its last byte leaves the input register.
// Only a frame held in the output register while m_axis_tready is low stalls the
// input, and then only when the next closing byte arrives.
module fixed_header_frame_receiver_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  fhfr_pkg::byte_t  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [15:0] roll_raw, [31:16] pitch_raw, [47:32] throttle_raw,
    // [63:48] rudder_raw, [79:64] waypoint_distance, [95:80] bearing_error,
    // [111:96] next_waypoint_alt, [127:112] energy_error,
    // [135:128] waypoint_index, [143:136] control_mode
    output fhfr_pkg::frame_t m_axis_tdata
);
    import fhfr_pkg::*;

    logic   in_valid;
    byte_t  in_data;
    logic   in_consume;
    logic   res_valid;
    logic   res_ready;
    frame_t res_data;

    fhfr_in_reg u_in_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .in_valid      (in_valid),
        .in_data       (in_data),
        .in_consume    (in_consume)
    );

    fhfr_frame u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .in_consume (in_consume),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    fhfr_out_reg u_out_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_data      (res_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    a_res_needs_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> in_valid)
        else $error("frame result without a byte in the input register");

    a_no_stall_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> in_valid && !in_consume)
        else $error("input stalled while input register is free");

    a_res_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> m_axis_tvalid)
        else $error("handed-off frame missing from output register");

    a_stall_only_on_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && !in_consume) |-> (res_valid && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked frame");

endmodule
